// ----- rtl/core/stcs_pkg.sv -----
`default_nettype none
package stcs_pkg;

  // screen and fixed point setup
  localparam int SCREEN_W     = 800;
  localparam int SCREEN_H     = 590;
  localparam int HALF_W       = SCREEN_W / 2;
  localparam int HALF_H       = SCREEN_H / 2;
  localparam int FRAC_BITS    = 8;
  localparam int CORDIC_STEPS = 16;
  localparam int TAB_LEN      = 24;
  localparam int NSTEPS       = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;

  // field and datapath widths
  localparam int SPD_W   = 16;
  localparam int CLICK_W = 10;
  localparam int POS_W   = 21;
  localparam int GOAL_W  = 11;
  localparam int HEAD_W  = 17;
  localparam int CGW     = GOAL_W + 1;      // centred click before clamp
  localparam int DX_W    = POS_W + 1;       // offset and multiplier operand
  localparam int MUL_W   = 2 * DX_W;
  localparam int CW      = 34;              // cordic x / y
  localparam int ANG_W   = 25;              // degrees q16
  localparam int IDX_W   = $clog2(TAB_LEN);

  // limits and constants
  localparam int POS_LIMIT  = 524288;
  localparam int HEAD_LIMIT = 46080;
  localparam int GOAL_MAX   = 1023;
  localparam int GOAL_MIN   = -1024;
  localparam int ANG90      = 5898240;
  localparam int KINV_Q16   = 39797;
  localparam int VEC_SHIFT  = 8;
  localparam int HEAD_SHIFT = 8;
  localparam int HEAD_RND   = 128;
  localparam int STEP_SHIFT = 16;
  localparam int STEP_RND   = 32768;
  localparam int SPD_RESET  = 2560;

  typedef logic signed [CW-1:0]    cval_t;
  typedef logic signed [ANG_W-1:0] ang_t;

  // control word for one micro-rotation
  typedef struct packed {
    logic             rot;   // 1: rotation mode, 0: vectoring mode
    logic [IDX_W-1:0] idx;   // iteration number
  } cordic_ctl_t;

  // atan(2^-i) in degrees q16, rounded to nearest
  function automatic ang_t atan_q16(input logic [IDX_W-1:0] i);
    ang_t a;
    unique case (i)
      5'd0:    a = ANG_W'(2949120);
      5'd1:    a = ANG_W'(1740967);
      5'd2:    a = ANG_W'(919879);
      5'd3:    a = ANG_W'(466945);
      5'd4:    a = ANG_W'(234379);
      5'd5:    a = ANG_W'(117304);
      5'd6:    a = ANG_W'(58666);
      5'd7:    a = ANG_W'(29335);
      5'd8:    a = ANG_W'(14668);
      5'd9:    a = ANG_W'(7334);
      5'd10:   a = ANG_W'(3667);
      5'd11:   a = ANG_W'(1833);
      5'd12:   a = ANG_W'(917);
      5'd13:   a = ANG_W'(458);
      5'd14:   a = ANG_W'(229);
      5'd15:   a = ANG_W'(115);
      5'd16:   a = ANG_W'(57);
      5'd17:   a = ANG_W'(29);
      5'd18:   a = ANG_W'(14);
      5'd19:   a = ANG_W'(7);
      5'd20:   a = ANG_W'(4);
      5'd21:   a = ANG_W'(2);
      5'd22:   a = ANG_W'(1);
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/stcs_cordic_step.sv -----
`default_nettype none
module stcs_cordic_step (
  input  stcs_pkg::cordic_ctl_t ctl,
  input  stcs_pkg::cval_t       x_in,
  input  stcs_pkg::cval_t       y_in,
  input  stcs_pkg::ang_t        ang_in,
  output stcs_pkg::cval_t       x_out,
  output stcs_pkg::cval_t       y_out,
  output stcs_pkg::ang_t        ang_out
);
  import stcs_pkg::*;

  cval_t xs;
  cval_t ys;
  ang_t  at;
  logic  fwd;

  assign xs = x_in >>> ctl.idx;
  assign ys = y_in >>> ctl.idx;
  assign at = atan_q16(ctl.idx);

  // vectoring drives y to zero, rotation drives the angle to zero
  assign fwd = ctl.rot ? (ang_in >= 0) : (y_in >= 0);

  always_comb begin
    if (ctl.rot == fwd) begin
      // rotation with angle >= 0, or vectoring with y < 0
      x_out = x_in - ys;
      y_out = y_in + xs;
    end else begin
      x_out = x_in + ys;
      y_out = y_in - xs;
    end
    if (fwd == ctl.rot) begin
      ang_out = ctl.rot ? (ang_in - at) : (ang_in - at);
    end else begin
      ang_out = ang_in + at;
    end
    if (!ctl.rot) begin
      ang_out = fwd ? (ang_in + at) : (ang_in - at);
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/seek_target_constant_speed.sv -----
// a click word stores the clamped target and goes straight to the done state
// a tick word squares the offset and the speed, then snaps, stands still or moves;
// a moving tick runs the shared cordic micro-rotation stage for 16 vectoring
// and then 16 rotation steps; a new word is taken only back in the idle state
// reset (rst_n low, synchronous): point, target and heading go to zero,
// step_speed to 2560 (10 px), no word pending on either side
`default_nettype none
module seek_target_constant_speed (
  input  wire                                   clk,
  input  wire                                   rst_n,
  // configuration
  input  wire                                   cfg_we,
  input  wire [stcs_pkg::SPD_W-1:0]             cfg_step_speed,
  // input channel
  input  wire                                   in_valid,
  output logic                                  in_ready,
  input  wire                                   in_mode,
  input  wire [stcs_pkg::CLICK_W-1:0]           in_click_x,
  input  wire [stcs_pkg::CLICK_W-1:0]           in_click_y,
  // result channel
  output logic                                  out_valid,
  input  wire                                   out_ready,
  output logic signed [stcs_pkg::POS_W-1:0]     out_position_x,
  output logic signed [stcs_pkg::POS_W-1:0]     out_position_y,
  output logic signed [stcs_pkg::HEAD_W-1:0]    out_heading,
  output logic                                  out_arrived
);
  import stcs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MX, S_MY, S_MS, S_CMP, S_VEC, S_RLD, S_ROT, S_UPD, S_DONE
  } state_t;

  state_t state_r;

  // architectural state
  logic signed [POS_W-1:0]  point_x_r;
  logic signed [POS_W-1:0]  point_y_r;
  logic signed [GOAL_W-1:0] goal_x_r;
  logic signed [GOAL_W-1:0] goal_y_r;
  logic signed [HEAD_W-1:0] heading_r;
  logic [SPD_W-1:0]         step_speed_r;

  // working registers
  logic signed [DX_W-1:0]  dx_r;
  logic signed [DX_W-1:0]  dy_r;
  logic signed [MUL_W-1:0] prod_r;
  logic signed [MUL_W:0]   acc_r;
  cval_t                   cx_r;
  cval_t                   cy_r;
  ang_t                    z_r;
  logic [IDX_W-1:0]        cnt_r;
  logic                    out_valid_r;

  // target in position format
  logic signed [DX_W-1:0] tx;
  logic signed [DX_W-1:0] ty;
  assign tx = DX_W'(goal_x_r) <<< FRAC_BITS;
  assign ty = DX_W'(goal_y_r) <<< FRAC_BITS;

  // click to centred coordinates, y up, clamped to the goal range
  logic signed [CGW-1:0]    cgx;
  logic signed [CGW-1:0]    cgy;
  logic signed [GOAL_W-1:0] gx_c;
  logic signed [GOAL_W-1:0] gy_c;
  always_comb begin
    cgx = $signed({2'b00, in_click_x}) - CGW'(HALF_W);
    cgy = CGW'(HALF_H) - $signed({2'b00, in_click_y});
    if (cgx > GOAL_MAX)      gx_c = GOAL_W'(GOAL_MAX);
    else if (cgx < GOAL_MIN) gx_c = GOAL_W'(GOAL_MIN);
    else                     gx_c = GOAL_W'(cgx);
    if (cgy > GOAL_MAX)      gy_c = GOAL_W'(GOAL_MAX);
    else if (cgy < GOAL_MIN) gy_c = GOAL_W'(GOAL_MIN);
    else                     gy_c = GOAL_W'(cgy);
  end

  // shared multiplier: dx^2, dy^2, speed^2, then speed / K
  logic signed [DX_W-1:0]  mul_a;
  logic signed [DX_W-1:0]  mul_b;
  logic signed [MUL_W-1:0] mul_p;
  logic signed [DX_W-1:0]  spd_s;
  assign spd_s = $signed({{(DX_W-SPD_W){1'b0}}, step_speed_r});
  always_comb begin
    case (state_r)
      S_MX: begin
        mul_a = dx_r;
        mul_b = dx_r;
      end
      S_MY: begin
        mul_a = dy_r;
        mul_b = dy_r;
      end
      S_MS: begin
        mul_a = spd_s;
        mul_b = spd_s;
      end
      default: begin
        mul_a = spd_s;
        mul_b = DX_W'(KINV_Q16);
      end
    endcase
  end
  assign mul_p = MUL_W'(mul_a) * MUL_W'(mul_b);

  // vectoring start: offset scaled, folded into the right half plane
  cval_t vx;
  cval_t vy;
  cval_t vx0;
  cval_t vy0;
  ang_t  vz0;
  always_comb begin
    vx = CW'(dx_r) <<< VEC_SHIFT;
    vy = CW'(dy_r) <<< VEC_SHIFT;
    if (vx < 0) begin
      if (vy >= 0) begin
        vx0 = vy;
        vy0 = -vx;
        vz0 = ANG_W'(ANG90);
      end else begin
        vx0 = -vy;
        vy0 = vx;
        vz0 = -ANG_W'(ANG90);
      end
    end else begin
      vx0 = vx;
      vy0 = vy;
      vz0 = '0;
    end
  end

  // rotation start: speed / K on an axis, residual angle within +-90
  cval_t spk;
  cval_t rx0;
  cval_t ry0;
  ang_t  rz0;
  always_comb begin
    spk = CW'(prod_r);
    if (z_r > ANG90) begin
      rx0 = '0;
      ry0 = spk;
      rz0 = z_r - ANG_W'(ANG90);
    end else if (z_r < -ANG90) begin
      rx0 = '0;
      ry0 = -spk;
      rz0 = z_r + ANG_W'(ANG90);
    end else begin
      rx0 = spk;
      ry0 = '0;
      rz0 = z_r;
    end
  end

  // heading: degrees q16 rounded to q8, saturated
  logic signed [ANG_W:0]    hsum;
  logic signed [ANG_W:0]    hq;
  logic signed [HEAD_W-1:0] head_c;
  always_comb begin
    hsum = (ANG_W+1)'(z_r) + (ANG_W+1)'(HEAD_RND);
    hq   = hsum >>> HEAD_SHIFT;
    if (hq > HEAD_LIMIT)       head_c = HEAD_W'(HEAD_LIMIT);
    else if (hq < -HEAD_LIMIT) head_c = -HEAD_W'(HEAD_LIMIT);
    else                       head_c = HEAD_W'(hq);
  end

  // position update: rounded step added and saturated
  logic signed [CW:0]      sx;
  logic signed [CW:0]      sy;
  logic signed [POS_W:0]   px_s;
  logic signed [POS_W:0]   py_s;
  logic signed [POS_W-1:0] px_c;
  logic signed [POS_W-1:0] py_c;
  always_comb begin
    sx   = ((CW+1)'(cx_r) + (CW+1)'(STEP_RND)) >>> STEP_SHIFT;
    sy   = ((CW+1)'(cy_r) + (CW+1)'(STEP_RND)) >>> STEP_SHIFT;
    px_s = (POS_W+1)'(point_x_r) + (POS_W+1)'(sx);
    py_s = (POS_W+1)'(point_y_r) + (POS_W+1)'(sy);
    if (px_s > POS_LIMIT)       px_c = POS_W'(POS_LIMIT);
    else if (px_s < -POS_LIMIT) px_c = -POS_W'(POS_LIMIT);
    else                        px_c = POS_W'(px_s);
    if (py_s > POS_LIMIT)       py_c = POS_W'(POS_LIMIT);
    else if (py_s < -POS_LIMIT) py_c = -POS_W'(POS_LIMIT);
    else                        py_c = POS_W'(py_s);
  end

  // shared micro-rotation stage
  cordic_ctl_t cctl;
  cval_t       step_x;
  cval_t       step_y;
  ang_t        step_z;
  assign cctl.rot = (state_r == S_ROT);
  assign cctl.idx = cnt_r;

  stcs_cordic_step u_step (
    .ctl     (cctl),
    .x_in    (cx_r),
    .y_in    (cy_r),
    .ang_in  (z_r),
    .x_out   (step_x),
    .y_out   (step_y),
    .ang_out (step_z)
  );

  logic last_iter;
  logic snap;
  logic at_goal;
  assign last_iter = (cnt_r == IDX_W'(NSTEPS - 1));
  assign snap      = (acc_r < (MUL_W+1)'(prod_r));
  assign at_goal   = (DX_W'(point_x_r) == tx) && (DX_W'(point_y_r) == ty);

  // sequencer, state and registered outputs
  always_ff @(posedge clk) begin
    prod_r <= mul_p;
    if (!rst_n) begin
      state_r      <= S_IDLE;
      point_x_r    <= '0;
      point_y_r    <= '0;
      goal_x_r     <= '0;
      goal_y_r     <= '0;
      heading_r    <= '0;
      step_speed_r <= SPD_W'(SPD_RESET);
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        step_speed_r <= cfg_step_speed;
      end
      // the done state reloads the output register itself
      if (out_valid_r && out_ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            if (in_mode) begin
              goal_x_r <= gx_c;
              goal_y_r <= gy_c;
              state_r  <= S_DONE;
            end else begin
              dx_r    <= tx - DX_W'(point_x_r);
              dy_r    <= ty - DX_W'(point_y_r);
              state_r <= S_MX;
            end
          end
        end
        S_MX: begin
          state_r <= S_MY;
        end
        S_MY: begin
          acc_r   <= (MUL_W+1)'(prod_r);
          state_r <= S_MS;
        end
        S_MS: begin
          acc_r   <= acc_r + (MUL_W+1)'(prod_r);
          state_r <= S_CMP;
        end
        S_CMP: begin
          if (snap) begin
            // within one step: land exactly on the target
            point_x_r <= POS_W'(tx);
            point_y_r <= POS_W'(ty);
            state_r   <= S_DONE;
          end else if (dx_r == 0 && dy_r == 0) begin
            // zero speed on target: direction of a null offset is 0
            heading_r <= '0;
            state_r   <= S_DONE;
          end else begin
            cx_r    <= vx0;
            cy_r    <= vy0;
            z_r     <= vz0;
            cnt_r   <= '0;
            state_r <= S_VEC;
          end
        end
        S_VEC: begin
          cx_r  <= step_x;
          cy_r  <= step_y;
          z_r   <= step_z;
          cnt_r <= cnt_r + 1'b1;
          if (last_iter) begin
            state_r <= S_RLD;
          end
        end
        S_RLD: begin
          heading_r <= head_c;
          cx_r      <= rx0;
          cy_r      <= ry0;
          z_r       <= rz0;
          cnt_r     <= '0;
          state_r   <= S_ROT;
        end
        S_ROT: begin
          cx_r  <= step_x;
          cy_r  <= step_y;
          z_r   <= step_z;
          cnt_r <= cnt_r + 1'b1;
          if (last_iter) begin
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          point_x_r <= px_c;
          point_y_r <= py_c;
          state_r   <= S_DONE;
        end
        S_DONE: begin
          // hand over once the output register is free
          if (!out_valid_r || out_ready) begin
            out_position_x <= point_x_r;
            out_position_y <= point_y_r;
            out_heading    <= heading_r;
            out_arrived    <= at_goal;
            out_valid_r    <= 1'b1;
            state_r        <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  // point always inside the saturation bounds
  a_pos_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    point_x_r >= -POS_LIMIT && point_x_r <= POS_LIMIT &&
    point_y_r >= -POS_LIMIT && point_y_r <= POS_LIMIT)
    else $error("point outside bounds");

  // heading always inside +-180 degrees
  a_head_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    heading_r >= -HEAD_LIMIT && heading_r <= HEAD_LIMIT)
    else $error("heading outside bounds");

  // a click never moves the point
  a_click_keeps_point: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_mode) |=> $stable(point_x_r) && $stable(point_y_r))
    else $error("click moved the point");

  // iteration counter stays within the table while iterating
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_VEC || state_r == S_ROT) |-> cnt_r <= IDX_W'(NSTEPS - 1))
    else $error("cordic iteration out of range");
`endif

endmodule
`default_nettype wire

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
module testbench;

  // kind of input word, carried on in_mode
  typedef enum logic {
    WORD_TICK  = 1'b0,
    WORD_CLICK = 1'b1
  } word_kind_t;

  // one result word as the block should present it
  typedef struct {
    logic signed [stcs_pkg::POS_W-1:0]  pos_x;
    logic signed [stcs_pkg::POS_W-1:0]  pos_y;
    logic signed [stcs_pkg::HEAD_W-1:0] hdg;
    logic                               arrived;
  } fix_t;

  // fixed point constants of the motion law
  localparam longint Q_ONE           = 256;        // one pixel in q8
  localparam longint VEC_GAIN        = 256;        // offset scale before vectoring
  localparam longint POS_BOUND       = 524288;
  localparam longint HDG_BOUND       = 46080;
  localparam longint QUARTER_TURN    = 5898240;    // 90 degrees in q16
  localparam longint INV_GAIN        = 39797;      // 1/K in q16
  localparam longint GOAL_LO         = -1024;
  localparam longint GOAL_HI         = 1023;
  localparam int     MICRO_ROTATIONS = 16;
  localparam int     SPEED_AT_RESET  = 2560;
  localparam int     HOLD_OFF_CYCLES = 300;
  localparam int     SETTLE_CYCLES   = 48;         // longer than a moving tick takes
  localparam int     DRAIN_LIMIT     = 4000;
  localparam int     PRINT_LIMIT     = 100;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // configuration port
  logic                          cfg_we = 1'b0;
  logic [stcs_pkg::SPD_W-1:0]    cfg_step_speed = '0;

  // input channel
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic                          in_mode = 1'b0;
  logic [stcs_pkg::CLICK_W-1:0]  in_click_x = '0;
  logic [stcs_pkg::CLICK_W-1:0]  in_click_y = '0;

  // result channel
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic signed [stcs_pkg::POS_W-1:0]   out_position_x;
  logic signed [stcs_pkg::POS_W-1:0]   out_position_y;
  logic signed [stcs_pkg::HEAD_W-1:0]  out_heading;
  logic                                out_arrived;

  // pacing knobs, percent of cycles
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  logic hold_out = 1'b0;      // long receiver hold-off in progress

  // predicted state of the block
  longint pt_x, pt_y;         // point, q8
  longint gl_x, gl_y;         // target, whole pixels
  longint hdg;                // heading, degrees q8
  longint speed;              // step per tick, q8

  fix_t fix_queue[$];         // predicted results, oldest first
  fix_t head_fix;
  int   err_count = 0;
  int   word_count = 0;       // results seen so far

  seek_target_constant_speed u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_step_speed (cfg_step_speed),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_click_x     (in_click_x),
    .in_click_y     (in_click_y),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_position_x (out_position_x),
    .out_position_y (out_position_y),
    .out_heading    (out_heading),
    .out_arrived    (out_arrived)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // motion predictor
  // ---------------------------------------------------------------------------

  function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // atan(2^-i) in degrees q16, rounded to nearest
  function automatic longint atan_step(input int i);
    case (i)
      0:       return 2949120;
      1:       return 1740967;
      2:       return 919879;
      3:       return 466945;
      4:       return 234379;
      5:       return 117304;
      6:       return 58666;
      7:       return 29335;
      8:       return 14668;
      9:       return 7334;
      10:      return 3667;
      11:      return 1833;
      12:      return 917;
      13:      return 458;
      14:      return 229;
      15:      return 115;
      default: return 0;
    endcase
  endfunction

  // one time tick: snap when close, else step along the offset direction
  function automatic void advance_point();
    longint tx, ty, dx, dy, x, y, z, r, nx, ny, t;
    tx = gl_x * Q_ONE;
    ty = gl_y * Q_ONE;
    dx = tx - pt_x;
    dy = ty - pt_y;
    // exact snap test on squared lengths
    if (dx * dx + dy * dy < speed * speed) begin
      pt_x = clamp_to(tx, -POS_BOUND, POS_BOUND);
      pt_y = clamp_to(ty, -POS_BOUND, POS_BOUND);
      return;
    end
    // zero speed sitting on the target: atan2(0,0) gives a zero heading
    if (dx == 0 && dy == 0) begin
      hdg = 0;
      return;
    end
    // vectoring: fold the left half plane onto the right, then rotate to the axis
    x = dx * VEC_GAIN;
    y = dy * VEC_GAIN;
    z = 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y;
        y = -t;
        z = QUARTER_TURN;
      end else begin
        x = -y;
        y = t;
        z = -QUARTER_TURN;
      end
    end
    for (int i = 0; i < MICRO_ROTATIONS; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z  = z + atan_step(i);
      end else begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z  = z - atan_step(i);
      end
      x = nx;
      y = ny;
    end
    // rotation: a vector of length speed/K turned to angle z
    r = z;
    if (r > QUARTER_TURN) begin
      x = 0;
      y = speed * INV_GAIN;
      r = r - QUARTER_TURN;
    end else if (r < -QUARTER_TURN) begin
      x = 0;
      y = -speed * INV_GAIN;
      r = r + QUARTER_TURN;
    end else begin
      x = speed * INV_GAIN;
      y = 0;
    end
    for (int i = 0; i < MICRO_ROTATIONS; i++) begin
      if (r >= 0) begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        r  = r - atan_step(i);
      end else begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        r  = r + atan_step(i);
      end
      x = nx;
      y = ny;
    end
    pt_x = clamp_to(pt_x + ((x + 32768) >>> 16), -POS_BOUND, POS_BOUND);
    pt_y = clamp_to(pt_y + ((y + 32768) >>> 16), -POS_BOUND, POS_BOUND);
    hdg  = clamp_to((z + 128) >>> 8, -HDG_BOUND, HDG_BOUND);
  endfunction

  // apply one accepted word to the predicted state, return the expected result
  function automatic fix_t predict_fix(input word_kind_t kind,
                                       input logic [stcs_pkg::CLICK_W-1:0] cx,
                                       input logic [stcs_pkg::CLICK_W-1:0] cy);
    fix_t f;
    if (kind == WORD_CLICK) begin
      // centred coordinates, y pointing up
      gl_x = clamp_to(longint'(cx) - stcs_pkg::HALF_W, GOAL_LO, GOAL_HI);
      gl_y = clamp_to(stcs_pkg::HALF_H - longint'(cy), GOAL_LO, GOAL_HI);
    end else begin
      advance_point();
    end
    f.pos_x   = pt_x[stcs_pkg::POS_W-1:0];
    f.pos_y   = pt_y[stcs_pkg::POS_W-1:0];
    f.hdg     = hdg[stcs_pkg::HEAD_W-1:0];
    f.arrived = (pt_x == gl_x * Q_ONE) && (pt_y == gl_y * Q_ONE);
    return f;
  endfunction

  // ---------------------------------------------------------------------------
  // result side: random stalls, long hold-off, in-order compare
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input longint got, input longint want);
    err_count++;
    // keep the log short when everything goes wrong
    if (err_count <= PRINT_LIMIT)
      $display("[%0t] result %0d: %s got %0d want %0d", $time, word_count, what, got, want);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (fix_queue.size() == 0) begin
        report_mismatch("unexpected word, position_x", out_position_x, 0);
      end else begin
        head_fix = fix_queue.pop_front();
        if (out_position_x !== head_fix.pos_x)
          report_mismatch("position_x", out_position_x, head_fix.pos_x);
        if (out_position_y !== head_fix.pos_y)
          report_mismatch("position_y", out_position_y, head_fix.pos_y);
        if (out_heading !== head_fix.hdg)
          report_mismatch("heading", out_heading, head_fix.hdg);
        if (out_arrived !== head_fix.arrived)
          report_mismatch("arrived", out_arrived, head_fix.arrived);
      end
      word_count++;
    end
    out_ready <= !hold_out && ($urandom_range(99) >= recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  // offer one word; valid stays high until the handshake, prediction at accept
  task automatic send_word(input word_kind_t kind,
                           input logic [stcs_pkg::CLICK_W-1:0] cx,
                           input logic [stcs_pkg::CLICK_W-1:0] cy);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_mode    <= kind;
    in_click_x <= cx;
    in_click_y <= cy;
    do @(posedge clk); while (!in_ready);
    fix_queue.push_back(predict_fix(kind, cx, cy));
  endtask

  // tick words carry junk in the click fields, the block must ignore it
  task automatic send_tick();
    int jx, jy;
    jx = $urandom_range(1023);
    jy = $urandom_range(1023);
    send_word(WORD_TICK, jx[stcs_pkg::CLICK_W-1:0], jy[stcs_pkg::CLICK_W-1:0]);
  endtask

  task automatic send_click(input int cx, input int cy);
    send_word(WORD_CLICK, cx[stcs_pkg::CLICK_W-1:0], cy[stcs_pkg::CLICK_W-1:0]);
  endtask

  // target choice: near the last one, anywhere on screen, or anywhere in the field range
  task automatic pick_click(output int cx, output int cy);
    int sel;
    sel = $urandom_range(99);
    if (sel < 30) begin
      cx = int'(clamp_to(gl_x + stcs_pkg::HALF_W + int'($urandom_range(60)) - 30, 0, 1023));
      cy = int'(clamp_to(stcs_pkg::HALF_H - gl_y + int'($urandom_range(60)) - 30, 0, 1023));
    end else if (sel < 90) begin
      cx = $urandom_range(stcs_pkg::SCREEN_W - 1);
      cy = $urandom_range(stcs_pkg::SCREEN_H - 1);
    end else begin
      cx = $urandom_range(1023);
      cy = $urandom_range(1023);
    end
  endtask

  // stop offering, wait for every predicted result, then let the block settle
  task automatic wait_results_drained();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (fix_queue.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (fix_queue.size() != 0) begin
      report_mismatch("results never delivered, count", fix_queue.size(), 0);
      fix_queue.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write, only called with the block idle
  task automatic set_step_speed(input int value);
    cfg_step_speed <= value[stcs_pkg::SPD_W-1:0];
    cfg_we         <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    speed = value & 16'hFFFF;
  endtask

  task automatic set_pace(input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // default speed: ticks from the origin, clicks at the corners, the centre and off screen
  task automatic test_clicks_and_ticks();
    set_pace(0, 0);
    send_tick();                 // already on target after reset
    send_click(0, 0);            // top left corner
    send_tick();
    send_tick();
    send_click(1023, 1023);      // largest field values, off screen
    send_tick();
    send_click(stcs_pkg::SCREEN_W - 1, stcs_pkg::SCREEN_H - 1);
    send_tick();
    send_click(stcs_pkg::HALF_W, stcs_pkg::HALF_H);   // screen centre
    send_word(WORD_TICK, 10'h3FF, 10'h3FF);
    send_word(WORD_TICK, 10'h000, 10'h000);
    wait_results_drained();
  endtask

  // fastest speed snaps, zero speed only turns, slowest speed creeps
  task automatic test_speed_extremes();
    set_step_speed(65535);
    send_click(stcs_pkg::HALF_W, stcs_pkg::HALF_H);
    repeat (4) send_tick();
    wait_results_drained();
    set_step_speed(0);
    send_tick();                 // on target with zero speed: heading clears
    send_click(0, stcs_pkg::SCREEN_H - 1);
    send_tick();                 // heading follows, point stays
    wait_results_drained();
    set_step_speed(1);
    send_tick();
    send_tick();
    wait_results_drained();
  endtask

  // click then a run of ticks; zero-length runs give back-to-back clicks
  task automatic run_random_phase(input int n_items, input int idle_pct,
                                  input int stall_pct, input int new_speed);
    int sent;
    int run_len;
    int cx, cy;
    sent = 0;
    wait_results_drained();
    set_step_speed(new_speed);
    set_pace(idle_pct, stall_pct);
    while (sent < n_items) begin
      pick_click(cx, cy);
      send_click(cx, cy);
      sent++;
      run_len = $urandom_range(30);
      for (int k = 0; k < run_len && sent < n_items; k++) begin
        send_tick();
        sent++;
      end
    end
  endtask

  task automatic test_random_traffic();
    run_random_phase(105, 0, 0, 65535);
    run_random_phase(105, 49, 0, $urandom_range(4096, 16384));
    run_random_phase(105, 0, 49, SPEED_AT_RESET);
    run_random_phase(105, 11, 11, $urandom_range(65535));
    wait_results_drained();
  endtask

  // receiver holds off long enough that the block backs up its input
  task automatic test_backpressure();
    int cx, cy;
    set_pace(0, 0);
    set_step_speed($urandom_range(2048, 12000));
    hold_out <= 1'b1;
    fork
      begin
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_out <= 1'b0;
      end
    join_none
    pick_click(cx, cy);
    send_click(cx, cy);
    repeat (19) send_tick();
    // sender pauses here until every result is back
    wait_results_drained();
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    pt_x  = 0;
    pt_y  = 0;
    gl_x  = 0;
    gl_y  = 0;
    hdg   = 0;
    speed = SPEED_AT_RESET;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_clicks_and_ticks();
    test_speed_extremes();
    test_random_traffic();
    test_backpressure();
    wait_results_drained();

    if (err_count == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

  // hang guard, far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/stcs_pkg.sv
rtl/core/stcs_cordic_step.sv
rtl/core/seek_target_constant_speed.sv
dv/testbench.sv
